FILE: rtl/sfrs_pkg.sv
// Shared types, codes and defaults of the SPI flash request sequencer.
package sfrs_pkg;

	// Default sizes of the request queue and of one flash page.
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int PAGE_BYTES_DEF  = 256;

	// Field widths.
	localparam int ACTION_W = 3;
	localparam int ADDR_W   = 24;
	localparam int COUNT_W  = 16;
	localparam int TAG_W    = 8;
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 9;
	localparam int KIND_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	// Request actions.
	localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_ERASE  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_READ   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_STATUS = 3'd3;

	// Input operations.
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_FINISH  = 1'b1;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_CMD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPC_RDSR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OPC_WREN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OPC_PP      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OPC_SE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OPC_READ    = 3'd5;

	// Configuration reset values.
	localparam logic [LEN_W-1:0]  POLL_LENGTH_RST = 9'd260;
	localparam logic [BYTE_W-1:0] OPC_RDSR_RST    = 8'h05;
	localparam logic [BYTE_W-1:0] OPC_WREN_RST    = 8'h06;
	localparam logic [BYTE_W-1:0] OPC_PP_RST      = 8'h02;
	localparam logic [BYTE_W-1:0] OPC_SE_RST      = 8'hD8;
	localparam logic [BYTE_W-1:0] OPC_READ_RST    = 8'h03;

	// Transfer lengths: opcode plus three address bytes, status read, write enable.
	localparam logic [LEN_W-1:0] LEN_HDR    = 9'd4;
	localparam logic [LEN_W-1:0] LEN_STATUS = 9'd2;
	localparam logic [LEN_W-1:0] LEN_WREN   = 9'd1;

	// What the transfer in flight is.
	typedef enum logic [2:0] {
		P_NONE     = 3'd0,
		P_POLL     = 3'd1,
		P_WREN     = 3'd2,
		P_WRITE    = 3'd3,
		P_ERASE    = 3'd4,
		P_READ     = 3'd5,
		P_STATUS   = 3'd6,
		P_FALLBACK = 3'd7
	} pend_t;

	// One queued request; the count is already clamped to a page.
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [ADDR_W-1:0]   addr;
		logic [LEN_W-1:0]    count;
		logic [TAG_W-1:0]    tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ISSUE,
		ST_EMIT_A,
		ST_EMIT_B
	} ctrl_state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic accept;
		logic issue;
		logic load_a;
		logic load_b;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic res_a_valid;
		logic res_b_valid;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/sfrs_ram.sv
// Generic single write port RAM with a registered read port.
module sfrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/sfrs_ctrl.sv
// Controller state machine of the SPI flash request sequencer.
module sfrs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sfrs_pkg::sts_t sts,
	output sfrs_pkg::cmd_t cmd
);
	import sfrs_pkg::*;

	ctrl_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands: take a request, read the queue head, issue, then
	// hand out up to two results.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				state_d   = ST_EMIT_A;
			end
			ST_EMIT_A: begin
				if (!sts.res_a_valid) begin
					state_d = ST_EMIT_B;
				end else if (sts.out_free) begin
					cmd.load_a = 1'b1;
					state_d    = ST_EMIT_B;
				end
			end
			ST_EMIT_B: begin
				if (!sts.res_b_valid) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.load_b = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/sfrs_datapath.sv
// Datapath: configuration, request queue, flash state, results and output register.
module sfrs_datapath #(
	parameter int QUEUE_DEPTH = sfrs_pkg::QUEUE_DEPTH_DEF,
	parameter int PAGE_BYTES  = sfrs_pkg::PAGE_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sfrs_pkg::cmd_t                    cmd,
	output sfrs_pkg::sts_t                    sts,
	input  logic                              cfg_we,
	input  logic [sfrs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfrs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              op,
	input  logic [sfrs_pkg::ACTION_W-1:0]     action,
	input  logic [sfrs_pkg::ADDR_W-1:0]       req_addr,
	input  logic [sfrs_pkg::COUNT_W-1:0]      byte_count,
	input  logic [sfrs_pkg::TAG_W-1:0]        tag,
	input  logic [sfrs_pkg::BYTE_W-1:0]       rx_status,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sfrs_pkg::KIND_W-1:0]       kind,
	output logic [sfrs_pkg::TAG_W-1:0]        done_tag,
	output logic [sfrs_pkg::BYTE_W-1:0]       status_data,
	output logic [sfrs_pkg::BYTE_W-1:0]       spi_opcode,
	output logic [sfrs_pkg::ADDR_W-1:0]       spi_addr,
	output logic [sfrs_pkg::LEN_W-1:0]        spi_length,
	output logic                              busy_res,
	output logic                              last
);
	import sfrs_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [COUNT_W-1:0] PAGE_CNT = COUNT_W'(PAGE_BYTES);

	// Configuration registers.
	logic [LEN_W-1:0]  poll_length_q;
	logic [BYTE_W-1:0] opc_rdsr_q, opc_wren_q, opc_pp_q, opc_se_q, opc_read_q;

	// Queue pointers and flash state.
	logic [PTR_W-1:0] head_q, tail_q, head_nx, tail_nx;
	logic             xfer_pending_q, flash_ready_q, busy_flag_q, wr_en_q;
	pend_t            pend_action_q;
	logic [TAG_W-1:0] pend_tag_q;

	// Result of the input step (A) and of the issue step (B).
	logic              res_a_valid_q, res_b_valid_q;
	logic [KIND_W-1:0] res_a_kind_q;
	logic [TAG_W-1:0]  res_a_tag_q;
	logic [BYTE_W-1:0] res_a_status_q;
	logic [BYTE_W-1:0] res_b_opcode_q;
	logic [ADDR_W-1:0] res_b_addr_q;
	logic [LEN_W-1:0]  res_b_len_q;

	logic out_valid_q;

	// Queue memory.
	entry_t wr_entry, head_entry;
	logic   queue_full, queue_empty, enq_we;

	assign head_nx     = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	assign tail_nx     = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
	assign queue_full  = (tail_nx == head_q);
	assign queue_empty = (head_q == tail_q);

	assign enq_we = cmd.accept && (op == OP_ENQUEUE) && (byte_count != '0) && !queue_full;

	// New entry with the count clamped to a page.
	always_comb begin
		wr_entry.action = action;
		wr_entry.addr   = req_addr;
		wr_entry.count  = (byte_count > PAGE_CNT) ? PAGE_CNT[LEN_W-1:0]
		                                          : byte_count[LEN_W-1:0];
		wr_entry.tag    = tag;
	end

	sfrs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (enq_we),
		.waddr (tail_q),
		.wdata (wr_entry),
		.raddr (head_q),
		.rdata (head_entry)
	);

	// Decode of the head request into the command it becomes.
	logic              need_wren;
	pend_t             iss_action;
	logic [BYTE_W-1:0] iss_opcode;
	logic [LEN_W-1:0]  iss_len;

	always_comb begin
		need_wren = !wr_en_q &&
		            (head_entry.action == ACT_WRITE || head_entry.action == ACT_ERASE);
		unique case (head_entry.action)
			ACT_WRITE: begin
				iss_action = P_WRITE;
				iss_opcode = opc_pp_q;
				iss_len    = LEN_HDR + head_entry.count;
			end
			ACT_ERASE: begin
				iss_action = P_ERASE;
				iss_opcode = opc_se_q;
				iss_len    = LEN_HDR;
			end
			ACT_READ: begin
				iss_action = P_READ;
				iss_opcode = opc_read_q;
				iss_len    = LEN_HDR + head_entry.count;
			end
			ACT_STATUS: begin
				iss_action = P_STATUS;
				iss_opcode = opc_rdsr_q;
				iss_len    = LEN_STATUS;
			end
			default: begin
				iss_action = P_FALLBACK;
				iss_opcode = opc_rdsr_q;
				iss_len    = LEN_STATUS;
			end
		endcase
	end

	// Input step result payload.
	logic [KIND_W-1:0] a_kind;
	logic [TAG_W-1:0]  a_tag;
	logic [BYTE_W-1:0] a_status;

	always_comb begin
		if (op == OP_ENQUEUE) begin
			a_kind   = (byte_count == '0) ? KIND_DONE : KIND_REJECT;
			a_tag    = tag;
			a_status = '0;
		end else begin
			a_kind   = KIND_DONE;
			a_tag    = pend_tag_q;
			a_status = (pend_action_q == P_STATUS) ? rx_status : '0;
		end
	end

	// Control state: configuration, pointers, flash state and result flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_length_q  <= POLL_LENGTH_RST;
			opc_rdsr_q     <= OPC_RDSR_RST;
			opc_wren_q     <= OPC_WREN_RST;
			opc_pp_q       <= OPC_PP_RST;
			opc_se_q       <= OPC_SE_RST;
			opc_read_q     <= OPC_READ_RST;
			head_q         <= '0;
			tail_q         <= '0;
			xfer_pending_q <= 1'b0;
			flash_ready_q  <= 1'b0;
			busy_flag_q    <= 1'b0;
			wr_en_q        <= 1'b0;
			pend_action_q  <= P_NONE;
			pend_tag_q     <= '0;
			res_a_valid_q  <= 1'b0;
			res_b_valid_q  <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			// Register writes; unknown indexes are dropped.
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_POLL_LENGTH: poll_length_q <= cfg_data;
					CFG_OPC_RDSR:    opc_rdsr_q    <= cfg_data[BYTE_W-1:0];
					CFG_OPC_WREN:    opc_wren_q    <= cfg_data[BYTE_W-1:0];
					CFG_OPC_PP:      opc_pp_q      <= cfg_data[BYTE_W-1:0];
					CFG_OPC_SE:      opc_se_q      <= cfg_data[BYTE_W-1:0];
					CFG_OPC_READ:    opc_read_q    <= cfg_data[BYTE_W-1:0];
					default: ;
				endcase
			end

			// Input step: enqueue, or the finish of the transfer in flight.
			if (cmd.accept) begin
				res_a_valid_q <= 1'b0;
				wr_en_q       <= 1'b0;
				if (op == OP_ENQUEUE) begin
					if (byte_count == '0 || queue_full) begin
						res_a_valid_q <= 1'b1;
					end else begin
						tail_q <= tail_nx;
					end
				end else if (xfer_pending_q) begin
					xfer_pending_q <= 1'b0;
					unique case (pend_action_q)
						P_POLL: begin
							if (!rx_status[0]) begin
								flash_ready_q <= 1'b1;
							end
						end
						P_WREN: begin
							wr_en_q <= 1'b1;
						end
						P_WRITE, P_ERASE: begin
							res_a_valid_q <= 1'b1;
							flash_ready_q <= 1'b0;
						end
						P_READ, P_STATUS: begin
							res_a_valid_q <= 1'b1;
						end
						default: ;
					endcase
				end
			end

			// Issue step: poll, head request, or go quiet.
			if (cmd.issue) begin
				res_b_valid_q <= 1'b0;
				if (!xfer_pending_q) begin
					if (!flash_ready_q) begin
						pend_action_q  <= P_POLL;
						xfer_pending_q <= 1'b1;
						res_b_valid_q  <= 1'b1;
					end else if (queue_empty) begin
						pend_action_q <= P_NONE;
						busy_flag_q   <= 1'b0;
					end else begin
						busy_flag_q    <= 1'b1;
						xfer_pending_q <= 1'b1;
						res_b_valid_q  <= 1'b1;
						if (need_wren) begin
							pend_action_q <= P_WREN;
						end else begin
							pend_action_q <= iss_action;
							pend_tag_q    <= head_entry.tag;
							head_q        <= head_nx;
						end
					end
				end
			end

			// Output register valid.
			if (cmd.load_a || cmd.load_b) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payloads and the output register.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_a_kind_q   <= a_kind;
			res_a_tag_q    <= a_tag;
			res_a_status_q <= a_status;
		end
		if (cmd.issue) begin
			if (!flash_ready_q) begin
				res_b_opcode_q <= opc_rdsr_q;
				res_b_addr_q   <= '0;
				res_b_len_q    <= poll_length_q;
			end else if (need_wren) begin
				res_b_opcode_q <= opc_wren_q;
				res_b_addr_q   <= '0;
				res_b_len_q    <= LEN_WREN;
			end else begin
				res_b_opcode_q <= iss_opcode;
				res_b_addr_q   <= head_entry.addr;
				res_b_len_q    <= iss_len;
			end
		end
		if (cmd.load_a) begin
			kind        <= res_a_kind_q;
			done_tag    <= res_a_tag_q;
			status_data <= res_a_status_q;
			spi_opcode  <= '0;
			spi_addr    <= '0;
			spi_length  <= '0;
			busy_res    <= busy_flag_q;
			last        <= !res_b_valid_q;
		end else if (cmd.load_b) begin
			kind        <= KIND_CMD;
			done_tag    <= '0;
			status_data <= '0;
			spi_opcode  <= res_b_opcode_q;
			spi_addr    <= res_b_addr_q;
			spi_length  <= res_b_len_q;
			busy_res    <= busy_flag_q;
			last        <= 1'b1;
		end
	end

	assign out_valid       = out_valid_q;
	assign sts.res_a_valid = res_a_valid_q;
	assign sts.res_b_valid = res_b_valid_q;
	assign sts.out_free    = !out_valid_q || out_ready;

`ifndef SYNTHESIS
	// An issue step with nothing in flight either starts a transfer or goes idle.
	a_issue_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && !xfer_pending_q) |=> (xfer_pending_q || !busy_flag_q))
		else $error("issue step left neither a transfer nor an idle sequencer");

	// A stored request never makes the queue look empty.
	a_enqueue_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		enq_we |=> (tail_q != head_q))
		else $error("enqueue wrapped the queue onto its head");

	// The flash only turns not ready on a finished write or erase.
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(flash_ready_q) |-> $past(cmd.accept && op == OP_FINISH))
		else $error("flash ready dropped without a finished transfer");
`endif

endmodule

FILE: rtl/spi_flash_request_sequencer_top.sv
// Top level of the SPI flash request sequencer.
//
//  channel  direction  handshake               payload
//  in       input      in_valid / in_ready     op action req_addr byte_count tag rx_status
//  out      output     out_valid / out_ready   kind done_tag status_data spi_opcode
//                                              spi_addr spi_length busy_res last
//  cfg      input      cfg_valid / cfg_ready   cfg_index cfg_data
//
// A request holds the sequencer through its states in order: accept, queue head
// read (registered RAM port), issue, and one slot for each of the two possible
// results. The last result is loaded into the output register in its result slot,
// and the next request is taken in the idle state that follows the second slot.
// A stalled output holds the sequencer in its result slots; the final result waits
// in the output register while the next request is taken. Reset clears pointers and
// flash state and restores configuration defaults at once; the queue memory is not cleared.
// Configuration writes are taken every cycle.
module spi_flash_request_sequencer_top #(
	parameter int QUEUE_DEPTH = sfrs_pkg::QUEUE_DEPTH_DEF,
	parameter int PAGE_BYTES  = sfrs_pkg::PAGE_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sfrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfrs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            op,
	input  logic [sfrs_pkg::ACTION_W-1:0]   action,
	input  logic [sfrs_pkg::ADDR_W-1:0]     req_addr,
	input  logic [sfrs_pkg::COUNT_W-1:0]    byte_count,
	input  logic [sfrs_pkg::TAG_W-1:0]      tag,
	input  logic [sfrs_pkg::BYTE_W-1:0]     rx_status,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sfrs_pkg::KIND_W-1:0]     kind,
	output logic [sfrs_pkg::TAG_W-1:0]      done_tag,
	output logic [sfrs_pkg::BYTE_W-1:0]     status_data,
	output logic [sfrs_pkg::BYTE_W-1:0]     spi_opcode,
	output logic [sfrs_pkg::ADDR_W-1:0]     spi_addr,
	output logic [sfrs_pkg::LEN_W-1:0]      spi_length,
	output logic                            busy_res,
	output logic                            last
);
	import sfrs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Configuration registers accept a write in any cycle.
	assign cfg_ready = 1'b1;

	sfrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sfrs_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.PAGE_BYTES  (PAGE_BYTES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.action      (action),
		.req_addr    (req_addr),
		.byte_count  (byte_count),
		.tag         (tag),
		.rx_status   (rx_status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.done_tag    (done_tag),
		.status_data (status_data),
		.spi_opcode  (spi_opcode),
		.spi_addr    (spi_addr),
		.spi_length  (spi_length),
		.busy_res    (busy_res),
		.last        (last)
	);

endmodule
